/* src/assert_macros.svh */
// assertion macros included by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, pre, post)
`define ASSERT_NEXT(label, pre, post)
`endif
`endif

/* src/frit_pkg.sv */
// constants, codes and control types of the recent id table
package frit_pkg;
	localparam int TABLE_ENTRIES = 1024;
	localparam int MAX_IDS = 8;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int SLOT_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
	localparam int HIST_D = TABLE_ENTRIES * MAX_IDS;
	localparam int HIST_AW = $clog2(HIST_D);
	localparam int IDS_W = 4;
	localparam int CFG_AW = 3;

	localparam logic [1:0] OP_UPDATE = 2'd0;
	localparam logic [1:0] OP_LOOKUP_ALL = 2'd1;
	localparam logic [1:0] OP_LOOKUP_LATEST = 2'd2;

	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_FULL = 2'd1;
	localparam logic [1:0] ERR_BAD_ID = 2'd2;

	localparam logic [63:0] NONE_ID = '1;

	localparam logic [CFG_AW-3:0] REG_IDS_IN_USE = '0;

	// result id source
	localparam logic [1:0] ID_SEL_NID = 2'd0;
	localparam logic [1:0] ID_SEL_NONE = 2'd1;
	localparam logic [1:0] ID_SEL_HIST = 2'd2;

	// history write source
	localparam logic [1:0] WSEL_NID = 2'd0;
	localparam logic [1:0] WSEL_NONE = 2'd1;
	localparam logic [1:0] WSEL_RDATA = 2'd2;

	typedef struct packed {
		logic capture;
		logic scan_inc;
		logic hit_set;
		logic insert;
		logic slot_clr;
		logic slot_set_top;
		logic slot_inc;
		logic slot_dec;
		logic hist_we;
		logic [1:0] hist_wsel;
		logic hist_rd_prev;
		logic out_load;
		logic [1:0] out_id_sel;
		logic [1:0] out_err;
		logic out_last;
	} frit_cmd_t;

	typedef struct packed {
		logic scan_end;
		logic key_match;
		logic found;
		logic [1:0] op;
		logic nid_none;
		logic full;
		logic slot_zero;
		logic slot_top;
		logic slot_last;
		logic out_free;
	} frit_status_t;
endpackage

/* src/frit_ifs.sv */
// valid/ready channels for request and result beats
interface frit_req_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [63:0] key_upper;
	logic [63:0] key_middle;
	logic [31:0] key_lower;
	logic signed [63:0] new_id;
	modport source(output valid, operation, key_upper, key_middle, key_lower, new_id,
		input ready);
	modport sink(input valid, operation, key_upper, key_middle, key_lower, new_id,
		output ready);
endinterface

interface frit_rsp_if;
	logic valid;
	logic ready;
	logic found;
	logic signed [63:0] id_value;
	logic [1:0] error_code;
	logic last;
	modport source(output valid, found, id_value, error_code, last, input ready);
	modport sink(input valid, found, id_value, error_code, last, output ready);
endinterface

/* src/feature_recent_id_table.sv */
// top level of the recent id table: config register, controller and datapath
//
// A table of up to TABLE_ENTRIES 160-bit keys, each with a newest-first
// history of MAX_IDS 64-bit ids. Keys are never removed, so the table fills
// from entry 0 upward and a fill count marks the valid entries; no clearing
// pass runs after reset. One request is handled at a time. A request first
// scans the stored keys one entry at a time (memory read, then compare)
// until it hits or reaches the fill count. After the scan an insert writes
// all MAX_IDS history slots (one a cycle), an update of a known key shifts
// the history with a read and a write per slot, and a lookup reads each
// slot and sends one result beat per slot, waiting while the result
// register is still full. Lookup-all reports ids_in_use slots (0 counts as
// 1, values above MAX_IDS as MAX_IDS); lookup-latest and updates send one
// beat. The last beat of a request has last set. Operation code 3 gives no
// beat. The result register lets a new request be taken while the final
// beat still waits. ids_in_use sits at byte address 0 of the apb port and
// should only be written while the block is idle.
module feature_recent_id_table import frit_pkg::*; (
	input logic clk,
	input logic arst_n,
	frit_req_if.sink req,
	frit_rsp_if.source rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [CFG_AW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	frit_cmd_t cmd;
	frit_status_t status;
	logic [IDS_W-1:0] ids_q;
	logic reg_hit;

	// register decode: one register, word 0
	assign reg_hit = (paddr[CFG_AW-1:2] == REG_IDS_IN_USE) && (paddr[1:0] == 2'b00);
	assign pready = 1'b1;
	assign prdata = reg_hit ? 32'(ids_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ids_q <= IDS_W'(1);
		end else if (psel && penable && pwrite && reg_hit) begin
			ids_q <= pwdata[IDS_W-1:0];
		end
	end

	frit_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.status(status),
		.cmd(cmd)
	);

	frit_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.ids_in_use(ids_q),
		.cmd(cmd),
		.status(status)
	);
endmodule

/* src/frit_datapath.sv */
// key and history memories, counters, request latch and result register
`include "assert_macros.svh"
module frit_datapath import frit_pkg::*; (
	input logic clk,
	input logic arst_n,
	frit_req_if.sink req,
	frit_rsp_if.source rsp,
	input logic [IDS_W-1:0] ids_in_use,
	input frit_cmd_t cmd,
	output frit_status_t status
);
	logic [63:0] key_upper_mem [TABLE_ENTRIES];
	logic [63:0] key_middle_mem [TABLE_ENTRIES];
	logic [31:0] key_lower_mem [TABLE_ENTRIES];
	logic [63:0] hist_mem [HIST_D];

	logic [1:0] op_q;
	logic [63:0] ku_q, km_q, nid_q;
	logic [31:0] kl_q;
	logic [CNT_W-1:0] count_q, scan_idx_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic found_q;
	logic [SLOT_W-1:0] slot_q, rd_slot;
	logic [63:0] rd_ku_q, rd_km_q, hist_rdata_q, hist_wdata;
	logic [31:0] rd_kl_q;
	logic [HIST_AW-1:0] hist_waddr, hist_raddr;
	logic [7:0] n_slots, ids_ext;
	logic out_valid_q, out_found_q, out_last_q;
	logic [63:0] out_id_q;
	logic [1:0] out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scan_idx_q <= '0;
			found_q <= 1'b0;
			slot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				scan_idx_q <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_inc) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (cmd.hit_set) found_q <= 1'b1;
			if (cmd.insert) count_q <= count_q + 1'b1;
			if (cmd.slot_clr) slot_q <= '0;
			else if (cmd.slot_set_top) slot_q <= SLOT_W'(MAX_IDS - 1);
			else if (cmd.slot_inc) slot_q <= slot_q + 1'b1;
			else if (cmd.slot_dec) slot_q <= slot_q - 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= req.operation;
			ku_q <= req.key_upper;
			km_q <= req.key_middle;
			kl_q <= req.key_lower;
			nid_q <= req.new_id;
		end
		if (cmd.hit_set) hit_idx_q <= scan_idx_q[IDX_W-1:0];
		else if (cmd.insert) hit_idx_q <= count_q[IDX_W-1:0];
		if (cmd.out_load) begin
			out_found_q <= found_q;
			out_err_q <= cmd.out_err;
			out_last_q <= cmd.out_last;
			case (cmd.out_id_sel)
				ID_SEL_NID: out_id_q <= nid_q;
				ID_SEL_HIST: out_id_q <= hist_rdata_q;
				default: out_id_q <= NONE_ID;
			endcase
		end
	end

	// key memories: written on insert at the fill count, read at the scan index
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			key_upper_mem[count_q[IDX_W-1:0]] <= ku_q;
			key_middle_mem[count_q[IDX_W-1:0]] <= km_q;
			key_lower_mem[count_q[IDX_W-1:0]] <= kl_q;
		end
		rd_ku_q <= key_upper_mem[scan_idx_q[IDX_W-1:0]];
		rd_km_q <= key_middle_mem[scan_idx_q[IDX_W-1:0]];
		rd_kl_q <= key_lower_mem[scan_idx_q[IDX_W-1:0]];
	end

	assign rd_slot = cmd.hist_rd_prev ? slot_q - 1'b1 : slot_q;
	assign hist_waddr = HIST_AW'(HIST_AW'(hit_idx_q) * HIST_AW'(MAX_IDS) + HIST_AW'(slot_q));
	assign hist_raddr = HIST_AW'(HIST_AW'(hit_idx_q) * HIST_AW'(MAX_IDS) + HIST_AW'(rd_slot));

	always_comb begin
		case (cmd.hist_wsel)
			WSEL_NID: hist_wdata = nid_q;
			WSEL_RDATA: hist_wdata = hist_rdata_q;
			default: hist_wdata = NONE_ID;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.hist_we) hist_mem[hist_waddr] <= hist_wdata;
		hist_rdata_q <= hist_mem[hist_raddr];
	end

	// slots reported by a lookup
	assign ids_ext = 8'(ids_in_use);
	always_comb begin
		if (op_q != OP_LOOKUP_ALL) n_slots = 8'd1;
		else if (ids_ext == 8'd0) n_slots = 8'd1;
		else if (ids_ext > 8'(MAX_IDS)) n_slots = 8'(MAX_IDS);
		else n_slots = ids_ext;
	end

	assign req.ready = 1'b0 | cmd.capture;
	assign status.scan_end = (scan_idx_q == count_q);
	assign status.key_match = (rd_ku_q == ku_q) && (rd_km_q == km_q) && (rd_kl_q == kl_q);
	assign status.found = found_q;
	assign status.op = op_q;
	assign status.nid_none = (nid_q == NONE_ID);
	assign status.full = (count_q == CNT_W'(TABLE_ENTRIES));
	assign status.slot_zero = (slot_q == '0);
	assign status.slot_top = (slot_q == SLOT_W'(MAX_IDS - 1));
	assign status.slot_last = ((8'(slot_q) + 8'd1) == n_slots);
	assign status.out_free = !out_valid_q || rsp.ready;

	assign rsp.valid = out_valid_q;
	assign rsp.found = out_found_q;
	assign rsp.id_value = out_id_q;
	assign rsp.error_code = out_err_q;
	assign rsp.last = out_last_q;

	`ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(TABLE_ENTRIES))
	`ASSERT_IMPL(a_insert_room, cmd.insert, !status.full && !found_q)
	`ASSERT_IMPL(a_load_free, cmd.out_load, status.out_free)
	`ASSERT_IMPL(a_scan_in_range, cmd.scan_inc, scan_idx_q < count_q)
endmodule

/* src/frit_ctrl.sv */
// sequencer for scan, insert, history shift and result beats
module frit_ctrl import frit_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input frit_status_t status,
	output frit_cmd_t cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN_RD = 4'd1;
	localparam logic [3:0] S_SCAN_CMP = 4'd2;
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_INIT = 4'd4;
	localparam logic [3:0] S_SH_RD = 4'd5;
	localparam logic [3:0] S_SH_WR = 4'd6;
	localparam logic [3:0] S_LK_RD = 4'd7;
	localparam logic [3:0] S_LK_EMIT = 4'd8;
	localparam logic [3:0] S_EMIT = 4'd9;

	logic [3:0] state_q, state_d;
	logic [1:0] err_q, err_d, idsel_q, idsel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q <= ERR_OK;
			idsel_q <= ID_SEL_NONE;
		end else begin
			state_q <= state_d;
			err_q <= err_d;
			idsel_q <= idsel_d;
		end
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		err_d = err_q;
		idsel_d = idsel_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				state_d = status.scan_end ? S_DECIDE : S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (status.key_match) begin
					cmd.hit_set = 1'b1;
					state_d = S_DECIDE;
				end else begin
					cmd.scan_inc = 1'b1;
					state_d = S_SCAN_RD;
				end
			end
			S_DECIDE: begin
				case (status.op)
					OP_UPDATE: begin
						if (status.nid_none) begin
							err_d = ERR_BAD_ID;
							idsel_d = ID_SEL_NONE;
							state_d = S_EMIT;
						end else if (status.found) begin
							cmd.slot_set_top = 1'b1;
							state_d = S_SH_RD;
						end else if (status.full) begin
							err_d = ERR_FULL;
							idsel_d = ID_SEL_NONE;
							state_d = S_EMIT;
						end else begin
							cmd.insert = 1'b1;
							cmd.slot_clr = 1'b1;
							state_d = S_INIT;
						end
					end
					OP_LOOKUP_ALL, OP_LOOKUP_LATEST: begin
						if (status.found) begin
							cmd.slot_clr = 1'b1;
							state_d = S_LK_RD;
						end else begin
							err_d = ERR_OK;
							idsel_d = ID_SEL_NONE;
							state_d = S_EMIT;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_INIT: begin
				cmd.hist_we = 1'b1;
				cmd.hist_wsel = status.slot_zero ? WSEL_NID : WSEL_NONE;
				if (status.slot_top) begin
					err_d = ERR_OK;
					idsel_d = ID_SEL_NID;
					state_d = S_EMIT;
				end else begin
					cmd.slot_inc = 1'b1;
				end
			end
			S_SH_RD: begin
				if (status.slot_zero) begin
					cmd.hist_we = 1'b1;
					cmd.hist_wsel = WSEL_NID;
					err_d = ERR_OK;
					idsel_d = ID_SEL_NID;
					state_d = S_EMIT;
				end else begin
					cmd.hist_rd_prev = 1'b1;
					state_d = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.hist_we = 1'b1;
				cmd.hist_wsel = WSEL_RDATA;
				cmd.slot_dec = 1'b1;
				state_d = S_SH_RD;
			end
			S_LK_RD: begin
				state_d = S_LK_EMIT;
			end
			S_LK_EMIT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_id_sel = ID_SEL_HIST;
					cmd.out_err = ERR_OK;
					cmd.out_last = status.slot_last;
					if (status.slot_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.slot_inc = 1'b1;
						state_d = S_LK_RD;
					end
				end
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_id_sel = idsel_q;
					cmd.out_err = err_q;
					cmd.out_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
